// File: design/efor_pkg.sv
package efor_pkg;

  // Sample format and gain format.
  localparam int SAMPLE_WIDTH     = 32;
  localparam int SAMPLE_FRAC_BITS = 16;
  localparam int GAIN_FRAC_BITS   = 16;

  // Derived widths.
  localparam int GAIN_WIDTH      = GAIN_FRAC_BITS + 1;
  localparam int LIMIT_WIDTH     = SAMPLE_WIDTH - 1;
  localparam int DIFF_WIDTH      = SAMPLE_WIDTH + 1;
  localparam int REL_SCALE       = 10;
  localparam int REL_SCALE_WIDTH = 4;
  localparam int SCALED_WIDTH    = DIFF_WIDTH + REL_SCALE_WIDTH;
  localparam int PROD_WIDTH      = LIMIT_WIDTH + SAMPLE_WIDTH;
  localparam int GPROD_WIDTH     = GAIN_WIDTH + DIFF_WIDTH;
  localparam int INC_WIDTH       = GPROD_WIDTH - GAIN_FRAC_BITS;
  localparam int SUM_WIDTH       = INC_WIDTH + 1;

  // Configuration port.
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = SAMPLE_WIDTH;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_SMOOTHING_GAIN = 2'd0,
    REG_OUTLIER_LIMIT  = 2'd1
  } cfg_reg_t;

  localparam logic [GAIN_WIDTH-1:0]  GAIN_ONE    = GAIN_WIDTH'(1) << GAIN_FRAC_BITS;
  localparam logic [GAIN_WIDTH-1:0]  GAIN_RESET  = GAIN_WIDTH'(6554);
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(131072);

  // Outcome of one sample: the new filtered value and the outlier flag.
  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] value;
    logic                           rejected;
  } step_t;

endpackage

// File: design/efor_datapath.sv
// Outlier test and filter update for one sample against the held value.
module efor_datapath (
  input  logic signed [efor_pkg::SAMPLE_WIDTH-1:0] sample,
  input  logic signed [efor_pkg::SAMPLE_WIDTH-1:0] held,
  input  logic                                     primed,
  input  logic [efor_pkg::GAIN_WIDTH-1:0]          gain,
  input  logic [efor_pkg::LIMIT_WIDTH-1:0]         limit,
  output efor_pkg::step_t                          step
);

  localparam int SW = efor_pkg::SAMPLE_WIDTH;
  localparam int DW = efor_pkg::DIFF_WIDTH;
  localparam int CW = efor_pkg::SCALED_WIDTH;
  localparam int PW = efor_pkg::PROD_WIDTH;
  localparam int GW = efor_pkg::GPROD_WIDTH;
  localparam int IW = efor_pkg::INC_WIDTH;
  localparam int UW = efor_pkg::SUM_WIDTH;

  localparam logic signed [SW-1:0] SAT_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_MIN = {1'b1, {(SW-1){1'b0}}};

  logic signed [DW-1:0] diff;
  logic [DW-1:0]        abs_diff;
  logic [SW-1:0]        mag;
  logic                 below_one;
  logic [CW-1:0]        scaled_diff;
  logic [PW-1:0]        limit_prod;
  logic                 outlier;
  logic [GW-1:0]        gain_prod;
  logic [IW-1:0]        inc;
  logic signed [UW-1:0] held_ext;
  logic signed [UW-1:0] inc_ext;
  logic signed [UW-1:0] sum;
  logic signed [SW-1:0] sat;

  assign diff      = DW'(sample) - DW'(held);
  assign abs_diff  = diff[DW-1] ? DW'(-diff) : DW'(diff);
  assign mag       = held[SW-1] ? SW'(-held) : SW'(held);
  assign below_one = (mag >> efor_pkg::SAMPLE_FRAC_BITS) == '0;

  // Relative: |diff|*10 > limit*|held| w/o division; |diff| > limit if |held|<1.
  assign scaled_diff = CW'(abs_diff) * CW'(efor_pkg::REL_SCALE);
  assign limit_prod  = PW'(limit) * PW'(mag);
  assign outlier     = below_one ? (abs_diff > DW'(limit)) :
                                   (PW'(scaled_diff) > limit_prod);

  // The increment magnitude is truncated, then takes the sign of the difference.
  assign gain_prod = GW'(gain) * GW'(abs_diff);
  assign inc       = gain_prod[GW-1:efor_pkg::GAIN_FRAC_BITS];
  assign held_ext  = UW'(held);
  assign inc_ext   = $signed({1'b0, inc});
  assign sum       = diff[DW-1] ? held_ext - inc_ext : held_ext + inc_ext;

  always_comb begin
    if (sum > UW'(SAT_MAX)) begin
      sat = SAT_MAX;
    end else if (sum < UW'(SAT_MIN)) begin
      sat = SAT_MIN;
    end else begin
      sat = sum[SW-1:0];
    end
  end

  always_comb begin
    if (!primed) begin
      step.value    = sample;
      step.rejected = 1'b0;
    end else if (outlier) begin
      step.value    = held;
      step.rejected = 1'b1;
    end else begin
      step.value    = sat;
      step.rejected = 1'b0;
    end
  end

endmodule

// File: design/ema_filter_outlier_reject.sv
// An accepted request waits in the input register; its result is registered in the output
// register, which drives out_valid, once the output side is free.
// Throughput: one request per cycle unless the output side stalls; the held-value feedback
// closes via held_r. A restart gives no result and does not wait for the output register.
// Reset (rst_n low, synchronous) clears the filter state and all valid flags, and
// loads the smoothing gain and outlier limit registers with their default values.
module ema_filter_outlier_reject (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic signed [efor_pkg::SAMPLE_WIDTH-1:0]    in_sample,
  input  logic                                        in_restart,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic signed [efor_pkg::SAMPLE_WIDTH-1:0]    out_smoothed,
  output logic                                        out_rejected,
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [efor_pkg::CFG_INDEX_WIDTH-1:0]        cfg_index,
  input  logic [efor_pkg::CFG_DATA_WIDTH-1:0]         cfg_data
);

  // Configuration registers. The gain is clamped to 1.0 when it is written, so the
  // datapath never sees a value above unity.
  logic [efor_pkg::GAIN_WIDTH-1:0]  gain_r;
  logic [efor_pkg::LIMIT_WIDTH-1:0] limit_r;
  logic [efor_pkg::GAIN_WIDTH-1:0]  gain_wr;

  assign cfg_ready = 1'b1;
  assign gain_wr   = (cfg_data[efor_pkg::GAIN_WIDTH-1:0] > efor_pkg::GAIN_ONE) ?
                     efor_pkg::GAIN_ONE : cfg_data[efor_pkg::GAIN_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= efor_pkg::GAIN_RESET;
      limit_r <= efor_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (efor_pkg::cfg_reg_t'(cfg_index))
        efor_pkg::REG_SMOOTHING_GAIN: gain_r  <= gain_wr;
        efor_pkg::REG_OUTLIER_LIMIT:  limit_r <= cfg_data[efor_pkg::LIMIT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Input register: one request waits here while its result is computed.
  logic                                     s1_valid_r;
  logic signed [efor_pkg::SAMPLE_WIDTH-1:0] s1_sample_r;
  logic                                     s1_restart_r;
  logic                                     s1_advance;
  logic                                     out_load;
  logic                                     out_valid_r;

  // A restart leaves no result behind, so it never waits on the output register.
  assign s1_advance = s1_valid_r && (s1_restart_r || !out_valid_r || out_ready);
  assign out_load   = s1_advance && !s1_restart_r;
  assign in_ready   = !s1_valid_r || s1_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample_r  <= in_sample;
      s1_restart_r <= in_restart;
    end
  end

  // Filter state and its registered update.
  logic signed [efor_pkg::SAMPLE_WIDTH-1:0] held_r;
  logic signed [efor_pkg::SAMPLE_WIDTH-1:0] held_nxt;
  logic                                     primed_r;
  logic                                     primed_nxt;
  efor_pkg::step_t                          step;

  efor_datapath u_datapath (
    .sample (s1_sample_r),
    .held   (held_r),
    .primed (primed_r),
    .gain   (gain_r),
    .limit  (limit_r),
    .step   (step)
  );

  always_comb begin
    held_nxt   = held_r;
    primed_nxt = primed_r;
    if (s1_advance) begin
      if (s1_restart_r) begin
        held_nxt   = '0;
        primed_nxt = 1'b0;
      end else begin
        held_nxt   = step.value;
        primed_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= '0;
      primed_r <= 1'b0;
    end else begin
      held_r   <= held_nxt;
      primed_r <= primed_nxt;
    end
  end

  // Output register: holds a finished result until the consumer takes it, while the
  // input register is already free for the next request.
  logic signed [efor_pkg::SAMPLE_WIDTH-1:0] out_smoothed_r;
  logic                                     out_rejected_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_smoothed_r <= step.value;
      out_rejected_r <= step.rejected;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_smoothed = out_smoothed_r;
  assign out_rejected = out_rejected_r;

`ifndef SYNTHESIS
  // A rejected sample must leave the filtered value untouched.
  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && step.rejected |=> held_r == $past(held_r))
    else $error("rejected sample changed the held value");

  // A restart clears the filter state.
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_advance && s1_restart_r |=> !primed_r && held_r == '0)
    else $error("restart did not clear the filter state");

  // Every result presented matches the state it produced, and the filter is primed.
  a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && primed_r && out_smoothed_r == held_r)
    else $error("result register disagrees with the held value");
`endif

endmodule
